### sv/cfra_pkg.sv
// Shared constants for the color flow ratio accumulator.
// Holds frame geometry defaults, field widths and level constants.
// No dependencies.
package cfra_pkg;
    localparam int FRAME_WIDTH_DEF = 1024;
    localparam int FRAME_ROWS_DEF  = 256;
    localparam int HISTORY_DEF     = 15;

    localparam int IDX_W    = 18;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int LEVEL_W  = 8;
    localparam int QUO_W    = 33;
    // Sum of up to 31 quotients of 33 bits plus the level offset.
    localparam int ACC_W    = 40;

    localparam int LEVEL_BIAS = 128;
    localparam int LEVEL_MAX  = 255;
endpackage

### sv/cfra_ram.sv
// Single-port synchronous memory with registered read data.
// Used for the previous-sample store and the product history store.
// Depends on nothing.
module cfra_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### sv/cfra_div.sv
// Iterative signed divider that forms (pi - pq) / (pi + pq), truncating.
// One quotient bit per cycle; a zero denominator yields zero.
// Depends on cfra_pkg.
module cfra_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [cfra_pkg::PROD_W-1:0] pi,
    input  logic signed [cfra_pkg::PROD_W-1:0] pq,
    output logic                              busy,
    output logic                              done,
    output logic signed [cfra_pkg::QUO_W-1:0]  quo
);
    localparam int W = cfra_pkg::PROD_W;

    logic signed [W:0] num;
    logic signed [W:0] den;
    logic [W:0]        num_abs;
    logic [W:0]        den_abs;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic              neg_reg;
    logic [W-1:0]      dmag_reg;
    logic [W-1:0]      q_reg;
    logic [W:0]        rem_reg;
    logic [W:0]        rem_sh;
    logic              ge;

    assign num     = (W+1)'(pi) - (W+1)'(pq);
    assign den     = (W+1)'(pi) + (W+1)'(pq);
    assign num_abs = num[W] ? -num : num;
    assign den_abs = den[W] ? -den : den;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign rem_sh = {rem_reg[W-1:0], q_reg[W-1]};
    assign ge     = rem_sh >= {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                neg_reg  <= num[W] ^ den[W];
                dmag_reg <= den_abs[W-1:0];
                rem_reg  <= '0;
                cnt_reg  <= '0;
                if (den == '0) begin
                    // Zero denominator contributes nothing.
                    q_reg    <= '0;
                    done_reg <= 1'b1;
                end else begin
                    q_reg    <= num_abs[W-1:0];
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
                q_reg    <= {q_reg[W-2:0], ge};
                cnt_reg  <= cnt_reg + 6'd1;
                busy_reg <= (cnt_reg != 6'(W - 1));
                done_reg <= (cnt_reg == 6'(W - 1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

### sv/color_flow_ratio_accumulator.sv
// Top level of the color flow ratio accumulator; uses cfra_pkg, cfra_ram and cfra_div.
// Each history slot is read back and divided by the 32-step divider, which runs once per
// slot; a slot with a zero denominator skips the division steps. In a pixel's first frame
// every slot is written first; an index beyond the frame goes straight to the output.
// Throughput: one pixel at a time; a new transaction is taken once the
// previous level sits in the output register. Reset: aresetn, synchronous, clears
// control state; memories are not cleared.
module color_flow_ratio_accumulator #(
    parameter int FRAME_WIDTH = cfra_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_ROWS  = cfra_pkg::FRAME_ROWS_DEF,
    parameter int HISTORY     = cfra_pkg::HISTORY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [17:0] pixel_index, [33:18] i_sample, [49:34] q_sample, [55:50] zero
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] out_index, [25:18] level, [31:26] zero
    output logic [31:0] m_tdata
);
    localparam int PIXELS  = FRAME_WIDTH * FRAME_ROWS;
    localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int HDEPTH  = HISTORY * PIXELS;
    localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int SLOT_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int SW      = cfra_pkg::SAMPLE_W;
    localparam int PW      = cfra_pkg::PROD_W;
    localparam int AW      = cfra_pkg::ACC_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDPRV = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_RDH   = 4'd4;
    localparam logic [3:0] ST_WAITH = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;

    logic [3:0]                   state_reg;
    logic [SLOT_W-1:0]            ring_slot_reg;
    logic                         started_reg;
    logic [cfra_pkg::IDX_W-1:0]   idx_reg;
    logic signed [SW-1:0]         ni_reg;
    logic signed [SW-1:0]         nq_reg;
    logic                         fend_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic signed [PW-1:0]         pi_reg;
    logic signed [PW-1:0]         pq_reg;
    logic signed [AW-1:0]         acc_reg;
    logic                         m_tvalid_reg;
    logic [31:0]                  m_tdata_reg;

    logic                         s_accept;
    logic                         in_range;
    logic [PIX_W-1:0]             pix_addr;
    logic [HADDR_W-1:0]           hist_addr;
    logic [2*SW-1:0]              prev_rdata;
    logic signed [SW-1:0]         mul_i;
    logic signed [SW-1:0]         mul_q;
    logic [2*PW-1:0]              hist_rdata;
    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic signed [cfra_pkg::QUO_W-1:0] div_quo;
    logic signed [AW-1:0]         level_sum;
    logic [cfra_pkg::LEVEL_W-1:0] level_val;
    logic                         out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_range = 32'(s_tdata[17:0]) < 32'(PIXELS);
    assign pix_addr = PIX_W'(idx_reg);
    assign hist_addr = HADDR_W'(32'(slot_reg) * 32'(PIXELS) + 32'(idx_reg));

    // Previous-sample store, {q, i} per pixel.
    cfra_ram #(.DEPTH(PIXELS), .WIDTH(2*SW), .ADDR_W(PIX_W)) u_prev (
        .aclk  (aclk),
        .we    (state_reg == ST_MUL),
        .re    (state_reg == ST_RDPRV),
        .addr  (pix_addr),
        .wdata ({nq_reg, ni_reg}),
        .rdata (prev_rdata)
    );

    // Product history store, {pq, pi} per slot and pixel.
    cfra_ram #(.DEPTH(HDEPTH), .WIDTH(2*PW), .ADDR_W(HADDR_W)) u_hist (
        .aclk  (aclk),
        .we    (state_reg == ST_WRITE),
        .re    (state_reg == ST_RDH),
        .addr  (hist_addr),
        .wdata ({pq_reg, pi_reg}),
        .rdata (hist_rdata)
    );

    assign div_start = (state_reg == ST_WAITH);

    cfra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pi      (hist_rdata[PW-1:0]),
        .pq      (hist_rdata[2*PW-1:PW]),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Multiplier operands: the pixel's own samples in its first frame.
    assign mul_i = started_reg ? $signed(prev_rdata[SW-1:0])    : ni_reg;
    assign mul_q = started_reg ? $signed(prev_rdata[2*SW-1:SW]) : nq_reg;

    // Clamp of the biased sum.
    assign level_sum = acc_reg + AW'(cfra_pkg::LEVEL_BIAS);
    always_comb begin
        if (level_sum < 0) begin
            level_val = '0;
        end else if (level_sum > AW'(cfra_pkg::LEVEL_MAX)) begin
            level_val = cfra_pkg::LEVEL_W'(cfra_pkg::LEVEL_MAX);
        end else begin
            level_val = level_sum[cfra_pkg::LEVEL_W-1:0];
        end
    end

    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    // Sequencer: read, update, write back, then sweep the history slots and present the level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ring_slot_reg <= '0;
            started_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        idx_reg  <= s_tdata[17:0];
                        ni_reg   <= $signed(s_tdata[33:18]);
                        nq_reg   <= $signed(s_tdata[49:34]);
                        fend_reg <= s_tlast;
                        acc_reg  <= '0;
                        state_reg <= in_range ? ST_RDPRV : ST_FIN;
                    end
                end
                ST_RDPRV: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    pi_reg    <= ni_reg * mul_i;
                    pq_reg    <= nq_reg * mul_q;
                    slot_reg  <= started_reg ? ring_slot_reg : '0;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (started_reg || slot_reg == SLOT_W'(HISTORY - 1)) begin
                        slot_reg  <= '0;
                        state_reg <= ST_RDH;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                ST_RDH: begin
                    state_reg <= ST_WAITH;
                end
                ST_WAITH: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        acc_reg <= acc_reg + AW'(div_quo);
                        if (slot_reg == SLOT_W'(HISTORY - 1)) begin
                            state_reg <= ST_FIN;
                        end else begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= ST_RDH;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, level_val, idx_reg};
                        if (fend_reg) begin
                            started_reg <= 1'b1;
                            ring_slot_reg <= (ring_slot_reg == SLOT_W'(HISTORY - 1)) ?
                                             '0 : ring_slot_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ring_slot_reg) < 32'(HISTORY))
        else $error("ring slot out of range");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the slot sweep");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result not presented after finishing a pixel");
endmodule

### tb/tb_top.sv
// Self-checking bench for color_flow_ratio_accumulator: directed table, then random pixels.
// A built-in predictor of the per-pixel ratio history gives each expected level not fixed by a row.
// Depends on cfra_pkg and the color_flow_ratio_accumulator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1620;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [cfra_pkg::IDX_W-1:0]    idx;
        logic [cfra_pkg::SAMPLE_W-1:0] i_smp;
        logic [cfra_pkg::SAMPLE_W-1:0] q_smp;
        logic                          fend;
        int                            lvl; // -1 means use the predictor
    } pixel_row_t;

    typedef struct {
        logic [cfra_pkg::IDX_W-1:0]   idx;
        logic [cfra_pkg::LEVEL_W-1:0] lvl;
    } level_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [55:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Predictor state: control registers and per-pixel stores.
    int     ring_pos;
    bit     first_done;
    longint last_i [int];
    longint last_q [int];
    longint hist_i [int];
    longint hist_q [int];

    level_t     level_queue[$];
    int         errors = 0;
    int         levels_seen = 0;
    int         cycles = 0;
    int         pixel_pool[$];
    pixel_row_t dir_rows[$];

    color_flow_ratio_accumulator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Updates the pixel history and returns the level for one pixel.
    function automatic logic [cfra_pkg::LEVEL_W-1:0] predict_level(int p,
            logic [cfra_pkg::SAMPLE_W-1:0] si, logic [cfra_pkg::SAMPLE_W-1:0] sq, logic fe);
        longint ni, nq, pi, pq, den, sum;
        ni = longint'($signed(si));
        nq = longint'($signed(sq));
        if (!first_done) begin
            for (int s = 0; s < cfra_pkg::HISTORY_DEF; s++) begin
                hist_i[p*32+s] = ni * ni;
                hist_q[p*32+s] = nq * nq;
            end
        end else begin
            hist_i[p*32+ring_pos] = ni * last_i[p];
            hist_q[p*32+ring_pos] = nq * last_q[p];
        end
        last_i[p] = ni;
        last_q[p] = nq;
        sum = 0;
        for (int s = 0; s < cfra_pkg::HISTORY_DEF; s++) begin
            pi = hist_i[p*32+s];
            pq = hist_q[p*32+s];
            den = pi + pq;
            if (den != 0) sum += (pi - pq) / den;
        end
        sum += cfra_pkg::LEVEL_BIAS;
        if (sum < 0) sum = 0;
        if (sum > cfra_pkg::LEVEL_MAX) sum = cfra_pkg::LEVEL_MAX;
        if (fe) begin
            first_done = 1'b1;
            ring_pos = (ring_pos + 1 == cfra_pkg::HISTORY_DEF) ? 0 : ring_pos + 1;
        end
        return sum[cfra_pkg::LEVEL_W-1:0];
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [cfra_pkg::SAMPLE_W-1:0] pick_sample();
        logic [cfra_pkg::SAMPLE_W-1:0] corner[5];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 4)];
        return cfra_pkg::SAMPLE_W'($urandom());
    endfunction

    // Offers one pixel and waits for its transaction, then queues the expected level.
    task automatic send_pixel(pixel_row_t row);
        int gap;
        level_t e;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, row.q_smp, row.i_smp, row.idx};
        s_tlast <= row.fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e.idx = row.idx;
        e.lvl = predict_level(int'(row.idx), row.i_smp, row.q_smp, row.fend);
        if (row.lvl >= 0) e.lvl = row.lvl[cfra_pkg::LEVEL_W-1:0];
        level_queue.push_back(e);
    endtask

    // Receiver readiness, with one long hold-off so the input stalls.
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held && levels_seen >= 200) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 1200)) @(posedge aclk);
        end
    end

    // Result checker: compares each transaction with the oldest expected level.
    always @(posedge aclk) begin
        level_t e;
        if (aresetn && m_tvalid && m_tready) begin
            levels_seen <= levels_seen + 1;
            if (level_queue.size() == 0) begin
                $display("%0t: unexpected level, actual idx=%0d level=%0d", $time,
                         m_tdata[17:0], m_tdata[25:18]);
                errors = errors + 1;
            end else begin
                e = level_queue.pop_front();
                if (m_tdata[17:0] !== e.idx) begin
                    $display("%0t: out_index expected %0d actual %0d", $time, e.idx,
                             m_tdata[17:0]);
                    errors = errors + 1;
                end
                if (m_tdata[25:18] !== e.lvl) begin
                    $display("%0t: level expected %0d actual %0d (idx %0d)", $time, e.lvl,
                             m_tdata[25:18], e.idx);
                    errors = errors + 1;
                end
            end
        end
    end

    // Stimulus: directed rows, then random pixels from the pool of the first frame.
    initial begin
        pixel_row_t row;
        ring_pos = 0;
        first_done = 1'b0;
        // First frame: every pixel used later appears here.
        dir_rows.push_back('{18'd0, 16'h0000, 16'h0000, 1'b0, 128});
        dir_rows.push_back('{18'h3FFFF, 16'h8000, 16'h0000, 1'b0, 143});
        dir_rows.push_back('{18'd5, 16'h0000, 16'h8000, 1'b0, 113});
        dir_rows.push_back('{18'd6, 16'h7FFF, 16'h7FFF, 1'b0, 128});
        dir_rows.push_back('{18'h2AAAA, 16'h8000, 16'h7FFF, 1'b0, -1});
        dir_rows.push_back('{18'h15555, 16'd100, 16'hFFF9, 1'b0, -1});
        dir_rows.push_back('{18'd7, 16'h0001, 16'hFFFF, 1'b1, -1});
        // Later frames: zero denominator against history, extremes, clamping.
        dir_rows.push_back('{18'd6, 16'h0001, 16'hFFFF, 1'b0, -1});
        dir_rows.push_back('{18'd0, 16'h8000, 16'h8000, 1'b0, -1});
        dir_rows.push_back('{18'h3FFFF, 16'h8000, 16'h7FFF, 1'b0, -1});
        dir_rows.push_back('{18'd5, 16'h7FFF, 16'h8000, 1'b1, -1});
        dir_rows.push_back('{18'd0, 16'h8000, 16'h7FFF, 1'b0, -1});
        dir_rows.push_back('{18'h2AAAA, 16'h7FFF, 16'h8000, 1'b0, -1});
        dir_rows.push_back('{18'h15555, 16'hFFFF, 16'h0001, 1'b1, -1});
        dir_rows.push_back('{18'd7, 16'h0000, 16'h0000, 1'b0, -1});
        pixel_pool = '{0, 262143, 5, 6, 'h2AAAA, 'h15555, 7};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) send_pixel(dir_rows[k]);
        for (int n = 0; n < N_RANDOM; n++) begin
            row.idx = cfra_pkg::IDX_W'(pixel_pool[$urandom_range(0, pixel_pool.size() - 1)]);
            row.i_smp = pick_sample();
            row.q_smp = pick_sample();
            row.fend = ($urandom_range(0, 19) == 0);
            row.lvl = -1;
            send_pixel(row);
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (level_queue.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
